[sv/smbd_pkg.sv]
// ----------------------------------------------------------------------------
// smbd_pkg
// Shared constants, sequencer states and request kinds of the SplitMix64
// bounded draw block.
// ----------------------------------------------------------------------------
package smbd_pkg;

   localparam int unsigned DRAW_W         = 64;
   localparam int unsigned HALF_W         = DRAW_W / 2;
   localparam int unsigned BOUND_BITS_DEF = 31;
   localparam int unsigned MUL_STEPS      = 3;

   localparam logic [DRAW_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [DRAW_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [DRAW_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

   localparam int unsigned MIX_SHIFT_A = 30;
   localparam int unsigned MIX_SHIFT_B = 27;
   localparam int unsigned MIX_SHIFT_C = 31;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_MUL_A,
      ST_MIX,
      ST_MUL_B,
      ST_FINISH,
      ST_DIVIDE,
      ST_REDUCE,
      ST_TEST,
      ST_DELIVER
   } state_type;

   typedef enum logic {
      KIND_RAW     = 1'b0,
      KIND_BOUNDED = 1'b1
   } kind_type;

endpackage

[sv/splitmix64_bounded_draw.sv]
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw
// SplitMix64 generator with raw 64-bit draws and unbiased draws below a bound,
// built around one shared 32x32 multiplier and a bit-serial remainder loop.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_    | in  | tuser: kind; tdata: bound (BOUND_BITS, zero padded)
//  rsp_    | out | tdata: value (64 bits)
//  csr_    | in  | wr_data: seed, loads the generator state
//
//  Raw draw: ADVANCE, MUL_A, MIX, MUL_B, FINISH, then DELIVER (6 multiplier passes).
//  Bounded draw, bound >= 2: each attempt adds a 64-step remainder loop, REDUCE, TEST;
//  a rejected draw repeats the attempt. Bound 0 or 1: straight to DELIVER, no draw.
//  Reset clears the generator state to zero; no clearing pass.
//  A response waiting on rsp_tready holds; the next request is still taken.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw #(
   parameter int unsigned BOUND_BITS = smbd_pkg::BOUND_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [smbd_pkg::DRAW_W-1:0]           csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((BOUND_BITS + 7) / 8) * 8-1:0] req_tdata,  // bound
   input  logic [0:0]                            req_tuser,  // kind
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [smbd_pkg::DRAW_W-1:0]           rsp_tdata   // value
);

   import smbd_pkg::*;

   localparam int unsigned CNT_W = $clog2(DRAW_W);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DRAW_W - 1);
   localparam logic [CNT_W-1:0] MUL_CROSS = CNT_W'(1);
   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);

   state_type               state_ff, state_in;
   kind_type                kind_ff;
   logic [BOUND_BITS-1:0]   bound_ff, rem_ff, rem_in, bound_req;
   logic [CNT_W-1:0]        cnt_ff;
   logic [DRAW_W-1:0]       gen_ff, gen_in, operand_ff, acc_ff, acc_in;
   logic [DRAW_W-1:0]       dividend_ff, base_ff, result_ff, out_ff, mix_out, mul_k;
   logic [HALF_W-1:0]       mul_x, mul_y;
   logic [DRAW_W-1:0]       prod;
   logic [BOUND_BITS:0]     div_trial, div_diff;
   logic [DRAW_W:0]         test_sum;
   logic                    out_valid_ff, out_free, deliver_fire, reject, small_bound;

   assign bound_req   = req_tdata[BOUND_BITS-1:0];
   assign small_bound = (bound_req >> 1) == '0;
   assign gen_in      = gen_ff + GOLDEN_INC;

   assign mul_k  = (state_ff == ST_MUL_B) ? MIX_MUL_B : MIX_MUL_A;
   assign mul_x  = (cnt_ff == MUL_LAST) ? operand_ff[DRAW_W-1:HALF_W] : operand_ff[HALF_W-1:0];
   assign mul_y  = (cnt_ff == MUL_CROSS) ? mul_k[DRAW_W-1:HALF_W] : mul_k[HALF_W-1:0];
   assign prod   = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
   assign acc_in = (cnt_ff == '0) ? prod :
                   {acc_ff[DRAW_W-1:HALF_W] + prod[HALF_W-1:0], acc_ff[HALF_W-1:0]};
   assign mix_out = acc_ff ^ (acc_ff >> MIX_SHIFT_C);

   assign div_trial = {rem_ff, dividend_ff[DRAW_W-1]};
   assign div_diff  = div_trial - {1'b0, bound_ff};
   assign rem_in    = (div_trial >= {1'b0, bound_ff}) ? div_diff[BOUND_BITS-1:0]
                                                      : div_trial[BOUND_BITS-1:0];

   // carry out means the draw's quotient reached the top, partial bucket
   assign test_sum = {1'b0, base_ff} + (DRAW_W + 1)'(bound_ff);
   assign reject   = test_sum[DRAW_W];

   assign out_free     = !out_valid_ff || rsp_tready;
   assign deliver_fire = (state_ff == ST_DELIVER) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (kind_type'(req_tuser) == KIND_BOUNDED && small_bound) begin
                  state_in = ST_DELIVER;
               end else begin
                  state_in = ST_ADVANCE;
               end
            end
         end
         ST_ADVANCE: state_in = ST_MUL_A;
         ST_MUL_A: begin
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: state_in = ST_MUL_B;
         ST_MUL_B: begin
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = (kind_ff == KIND_BOUNDED) ? ST_DIVIDE : ST_DELIVER;
         ST_DIVIDE: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: state_in = ST_TEST;
         ST_TEST: state_in = reject ? ST_ADVANCE : ST_DELIVER;
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            gen_ff <= csr_wr_data;
         end else if (state_ff == ST_ADVANCE) begin
            gen_ff <= gen_in;
         end
         if (deliver_fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_MUL_A || state_ff == ST_MUL_B || state_ff == ST_DIVIDE) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            cnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_ff   <= kind_type'(req_tuser);
               bound_ff  <= bound_req;
               result_ff <= '0;
            end
         end
         ST_ADVANCE: operand_ff <= gen_in ^ (gen_in >> MIX_SHIFT_A);
         ST_MUL_A, ST_MUL_B: acc_ff <= acc_in;
         ST_MIX: operand_ff <= acc_ff ^ (acc_ff >> MIX_SHIFT_B);
         ST_FINISH: begin
            result_ff   <= mix_out;
            dividend_ff <= mix_out;
            rem_ff      <= '0;
         end
         ST_DIVIDE: begin
            dividend_ff <= dividend_ff << 1;
            rem_ff      <= rem_in;
         end
         ST_REDUCE: base_ff <= result_ff - DRAW_W'(rem_ff);
         ST_TEST: result_ff <= DRAW_W'(rem_ff);
         default: ;
      endcase
      if (deliver_fire) begin
         out_ff <= result_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   a_rem_below_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> rem_ff < bound_ff)
      else $error("remainder not below bound");

   a_bounded_range: assert property (@(posedge clock) disable iff (reset)
      (deliver_fire && kind_ff == KIND_BOUNDED) |=>
         (rsp_tdata < DRAW_W'($past(bound_ff)) || rsp_tdata == '0))
      else $error("bounded result out of range");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ADVANCE && !csr_wr_en) |=> $stable(gen_ff))
      else $error("generator state moved without a draw");

   a_small_bound: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && kind_type'(req_tuser) == KIND_BOUNDED && small_bound)
         |=> state_ff == ST_DELIVER)
      else $error("trivial bound did not skip the draw");

endmodule
